>>> rtl/core/shc_pkg.sv
// Shared constants and types for the smooth histogram checkpoint block.
package shc_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxBits    = $clog2(MaxEntries);
  localparam int unsigned LiveBits   = $clog2(MaxEntries + 1);
  localparam int unsigned CountBits  = 32;
  localparam int unsigned ArrBits    = 32;
  localparam int unsigned RatioBits  = 16;
  localparam int unsigned BatchBits  = 16;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CfgKeepRatio = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgBatchSize = 1'b1;

  localparam logic [RatioBits-1:0] KeepRatioRst = 16'd58982;
  localparam logic [BatchBits-1:0] BatchSizeRst = 16'd1;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [ArrBits-1:0]   ArrMax   = '1;

  typedef struct packed {
    logic [ArrBits-1:0]   origin_arrival;
    logic [CountBits-1:0] seen_count;
    logic                 last_entry;
    logic                 overflowed;
  } shc_out_t;

  typedef struct packed {
    logic report;
  } shc_in_t;

endpackage

>>> rtl/core/shc_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface shc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/shc_reach.sv
// Exact pruning compare: count * 65536 >= ratio * anchor, one multiplier.
module shc_reach (
  input  logic [shc_pkg::CountBits-1:0] count_i,
  input  logic [shc_pkg::CountBits-1:0] anchor_i,
  input  logic [shc_pkg::RatioBits-1:0] ratio_i,
  output logic                          reach_o
);
  import shc_pkg::*;

  logic [CountBits+RatioBits-1:0] lhs;
  logic [CountBits+RatioBits-1:0] rhs;

  assign lhs     = {count_i, {RatioBits{1'b0}}};
  assign rhs     = anchor_i * ratio_i;
  assign reach_o = lhs >= rhs;
endmodule

>>> rtl/core/smooth_histogram_checkpoints.sv
// Smooth histogram checkpoint list: sequencer, entry memory and output stage.
// Each arrival bumps every entry count, drops the oldest entry when the list is full,
// appends a new entry, then prunes the list against each anchor entry in turn.
// Each input item runs batch_size arrivals; reported words go out one per cycle
// unless held by back-pressure; input not ready meanwhile.
// Reset (rst_ni low, async) empties the list, clears counters, loads register defaults.
module smooth_histogram_checkpoints (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [shc_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [shc_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  shc_stream_if.sink                       in_if,
  shc_stream_if.source                     out_if
);
  import shc_pkg::*;

  // Sequencer states.
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StIncr   = 4'd1;  // bump every count, one entry a cycle
  localparam logic [3:0] StShift  = 4'd2;  // drop oldest on full list
  localparam logic [3:0] StAppend = 4'd3;
  localparam logic [3:0] StAnchor = 4'd4;  // fetch anchor entry
  localparam logic [3:0] StScan   = 4'd5;  // compare and compact, keep newest at end
  localparam logic [3:0] StLatch  = 4'd6;  // latch anchor count, fetch first candidate
  localparam logic [3:0] StEmit   = 4'd7;
  localparam logic [3:0] StHold   = 4'd8;  // wait on output stage

  logic [3:0] state_q, state_d;

  logic [RatioBits-1:0] ratio_q;
  logic [BatchBits-1:0] batch_q;

  logic [LiveBits-1:0]  live_q, live_d;
  logic [ArrBits-1:0]   arr_q, arr_d;
  logic                 ovf_q, ovf_d;
  logic                 report_q, report_d;
  logic [BatchBits-1:0] left_q, left_d;

  // Walk pointers: i anchor, j read, w write.
  logic [LiveBits-1:0]  i_q, i_d, j_q, j_d, w_q, w_d;
  logic [CountBits-1:0] anchor_q, anchor_d;

  // Entry memory, origin and count side by side.
  logic [ArrBits+CountBits-1:0] mem_q [MaxEntries];
  logic [ArrBits+CountBits-1:0]  rd_q;
  logic                          we;
  logic [IdxBits-1:0]            waddr;
  logic [ArrBits+CountBits-1:0]  wdata;
  logic [IdxBits-1:0]            raddr;
  logic                          rd_anchor;
  logic [ArrBits-1:0]            rd_org;
  logic [CountBits-1:0]          rd_cnt;

  // Registered read: the address of the next entry goes out in the cycle before,
  // so rd_q holds entry j whenever a state walks j. A read of the address
  // written in the same cycle returns the old entry.
  assign rd_org = rd_q[ArrBits+CountBits-1:CountBits];
  assign rd_cnt = rd_q[CountBits-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  logic reach;
  shc_reach u_reach (
    .count_i (rd_cnt),
    .anchor_i(anchor_q),
    .ratio_i (ratio_q),
    .reach_o (reach)
  );

  // Output stage.
  logic     out_vld_q, out_vld_d;
  shc_out_t out_q, out_d;

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;
  assign in_if.ready  = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    live_d    = live_q;
    arr_d     = arr_q;
    ovf_d     = ovf_q;
    report_d  = report_q;
    left_d    = left_q;
    i_d       = i_q;
    j_d       = j_q;
    w_d       = w_q;
    anchor_d  = anchor_q;
    we        = 1'b0;
    waddr     = w_q[IdxBits-1:0];
    wdata     = rd_q;
    rd_anchor = 1'b0;
    out_vld_d = out_vld_q && !out_if.ready;
    out_d     = out_q;

    case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          report_d = in_if.data.report;
          left_d   = batch_q;
          j_d      = '0;
          state_d  = (batch_q == '0) ? StEmit : StIncr;
        end
      end
      StIncr: begin
        if (j_q == live_q) begin
          // Advance the arrival count, then make room or append.
          if (arr_q != ArrMax) arr_d = arr_q + 1'b1;
          j_d     = LiveBits'(1);
          w_d     = '0;
          state_d = (live_q == LiveBits'(MaxEntries)) ? StShift : StAppend;
        end else begin
          we    = 1'b1;
          waddr = j_q[IdxBits-1:0];
          wdata = {rd_org, (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 1'b1};
          j_d   = j_q + 1'b1;
        end
      end
      StShift: begin
        if (j_q == LiveBits'(MaxEntries)) begin
          live_d  = LiveBits'(MaxEntries - 1);
          ovf_d   = 1'b1;
          state_d = StAppend;
        end else begin
          we    = 1'b1;
          waddr = w_q[IdxBits-1:0];
          wdata = rd_q;
          w_d   = w_q + 1'b1;
          j_d   = j_q + 1'b1;
        end
      end
      StAppend: begin
        we      = 1'b1;
        waddr   = live_q[IdxBits-1:0];
        wdata   = {arr_q, CountBits'(1)};
        live_d  = live_q + 1'b1;
        i_d     = '0;
        state_d = StAnchor;
      end
      StAnchor: begin
        if (i_q + 1'b1 >= live_q) begin
          left_d  = left_q - 1'b1;
          j_d     = '0;
          state_d = (left_q == BatchBits'(1)) ? StEmit : StIncr;
        end else begin
          rd_anchor = 1'b1;
          state_d   = StLatch;
        end
      end
      StLatch: begin
        anchor_d = rd_cnt;
        j_d      = i_q + 1'b1;
        w_d      = i_q + 1'b1;
        state_d  = StScan;
      end
      StScan: begin
        if (j_q + 1'b1 >= live_q) begin
          // j sits on the newest entry; keep it behind the survivors.
          we      = 1'b1;
          waddr   = w_q[IdxBits-1:0];
          wdata   = rd_q;
          live_d  = w_q + 1'b1;
          i_d     = i_q + 1'b1;
          state_d = StAnchor;
        end else begin
          if (!reach) begin
            we    = 1'b1;
            waddr = w_q[IdxBits-1:0];
            wdata = rd_q;
            w_d   = w_q + 1'b1;
          end
          j_d = j_q + 1'b1;
        end
      end
      StEmit: begin
        if (!report_q || j_q == live_q) begin
          state_d = StIdle;
        end else if (!out_vld_q || out_if.ready) begin
          out_vld_d = 1'b1;
          out_d.origin_arrival = rd_org;
          out_d.seen_count     = rd_cnt;
          out_d.last_entry     = (j_q + 1'b1 == live_q);
          out_d.overflowed     = ovf_q;
          j_d = j_q + 1'b1;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_if.ready) state_d = StEmit;
      end
      default: state_d = StIdle;
    endcase

    raddr = rd_anchor ? i_q[IdxBits-1:0] : j_d[IdxBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ratio_q   <= KeepRatioRst;
      batch_q   <= BatchSizeRst;
      live_q    <= '0;
      arr_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      live_q    <= live_d;
      arr_q     <= arr_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && cfg_idx_i == CfgKeepRatio) ratio_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CfgBatchSize) batch_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    report_q <= report_d;
    left_q   <= left_d;
    i_q      <= i_d;
    j_q      <= j_d;
    w_q      <= w_d;
    anchor_q <= anchor_d;
    out_q    <= out_d;
  end

  // Hold: a pending word must not change until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(out_q))
    else $error("output word changed while stalled");
  // The list never exceeds its depth.
  a_live_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LiveBits'(MaxEntries))
    else $error("live count beyond depth");
  // The overflow flag is sticky.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

endmodule
